// File: design/dlst_pkg.sv
// Package for the dense leaf slot table: payload structs, codes and defaults.
`timescale 1ns / 1ps
package dlst_pkg;

	localparam int DefSlots       = 1024;
	localparam int DefWordBits    = 64;
	localparam int DefValueBits   = 64;
	localparam int DefPrefixBytes = 8;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_SCAN   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ABSENT   = 3'd1;
	localparam logic [2:0] ST_WRONGLEN = 3'd2;
	localparam logic [2:0] ST_NORANGE  = 3'd3;
	localparam logic [2:0] ST_SLIGHT   = 3'd4;
	localparam logic [2:0] ST_FAR      = 3'd5;
	localparam logic [2:0] ST_CONVERT  = 3'd6;
	localparam logic [2:0] ST_SCANEND  = 3'd7;

	localparam logic [2:0] CFG_FULL_KEY_LEN = 3'd0;
	localparam logic [2:0] CFG_FENCE_BYTES  = 3'd1;
	localparam logic [2:0] CFG_FENCE_LEN    = 3'd2;
	localparam logic [2:0] CFG_NUMERIC_LEN  = 3'd3;
	localparam logic [2:0] CFG_ARRAY_START  = 3'd4;
	localparam logic [2:0] CFG_SLOT_COUNT   = 3'd5;
	localparam logic [2:0] CFG_VALUE_LEN    = 3'd6;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  key_len;
		logic [63:0] key_prefix;
		logic [31:0] key_tail;
		logic [63:0] payload;
		logic [3:0]  payload_len;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot_index;
		logic [31:0] key_numeric;
		logic [63:0] value_out;
		logic [3:0]  value_len_out;
	} rsp_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] bytes);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < bytes) m[b*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

// File: design/dense_leaf_slot_table_core.sv
// Top level of the dense leaf slot table: checks, slot mapping, bitmap and value store.
`timescale 1ns / 1ps
// States from the accepting edge to done: an item refused by the length or prefix checks goes
// straight to S_OUT; an out-of-range index passes S_INDEX; insert, remove and a lookup miss pass
// S_INDEX and S_POINT; a lookup hit passes S_INDEX, S_POINT and S_READ. Scan-next visiting W
// bitmap words (W up to WORDS) passes S_INDEX and S_SCAN, then S_READ on a hit. busy holds
// through the done cycle, so items are one at a time; the receiver cannot stall. Reset clears
// the sequencer, response, bitmap, idx, word and hit at once; req, pay, num and values are not.
module dense_leaf_slot_table_core #(
	parameter int SLOTS        = dlst_pkg::DefSlots,
	parameter int WORD_BITS    = dlst_pkg::DefWordBits,
	parameter int VALUE_BITS   = dlst_pkg::DefValueBits,
	parameter int PREFIX_BYTES = dlst_pkg::DefPrefixBytes
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dlst_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output dlst_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [63:0]    cfg_data
);
	import dlst_pkg::*;

	localparam int WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = IW + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INDEX = 3'd1;
	localparam logic [2:0] S_POINT = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	// Configuration registers.
	logic [3:0]  full_key_len_q, fence_len_q, value_len_q;
	logic [63:0] fence_bytes_q;
	logic [2:0]  numeric_len_q;
	logic [31:0] array_start_q;
	logic [10:0] slot_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_key_len_q <= 4'd4;
			fence_bytes_q  <= '0;
			fence_len_q    <= '0;
			numeric_len_q  <= 3'd4;
			array_start_q  <= '0;
			slot_count_q   <= 11'd1024;
			value_len_q    <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FULL_KEY_LEN: full_key_len_q <= cfg_data[3:0];
				CFG_FENCE_BYTES:  fence_bytes_q  <= cfg_data;
				CFG_FENCE_LEN:    fence_len_q    <= cfg_data[3:0];
				CFG_NUMERIC_LEN:  numeric_len_q  <= cfg_data[2:0];
				CFG_ARRAY_START:  array_start_q  <= cfg_data[31:0];
				CFG_SLOT_COUNT:   slot_count_q   <= cfg_data[10:0];
				CFG_VALUE_LEN:    value_len_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Derived, saturated configuration.
	logic [CW-1:0] count;
	logic [CW:0]   count_x15;
	logic [3:0]    pfx_cmp, vbytes;
	logic [2:0]    nlen;
	logic [63:0]   vmask;

	always_comb begin
		count = (32'(slot_count_q) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(slot_count_q);
		count_x15 = (CW+1)'(count) + (CW+1)'(count >> 1);
		pfx_cmp = (32'(fence_len_q) > 32'(PREFIX_BYTES)) ? 4'(PREFIX_BYTES) : fence_len_q;
		nlen    = (numeric_len_q > 3'd4) ? 3'd4 : numeric_len_q;
		vbytes  = (value_len_q > 4'd8) ? 4'd8 : value_len_q;
		vmask   = byte_mask(vbytes);
		if (VALUE_BITS < 64) vmask = vmask & ((64'd1 << VALUE_BITS) - 64'd1);
	end

	// Sequencer state and item registers.
	logic [2:0]    state_q;
	logic [1:0]    req_q;
	logic [63:0]   pay_q;
	logic [31:0]   num_q;
	logic [31:0]   idx_q;
	logic [WW-1:0] word_q;
	rsp_t          rsp_q;
	logic          done_q;
	logic          hit_q;

	// Presence bitmap, one word per row, cleared at reset.
	logic [WORD_BITS-1:0] pres_q [WORDS];
	// Value store.
	logic [VALUE_BITS-1:0] vals [SLOTS];
	logic [VALUE_BITS-1:0] vrd_q;

	logic [WW-1:0] idx_word;
	logic [BW-1:0] idx_bit;
	assign idx_word = WW'(idx_q[IW-1:0] / WORD_BITS);
	assign idx_bit  = BW'(idx_q[IW-1:0] % WORD_BITS);

	// Scan: mask bits below the start slot on the first word and at or above count.
	logic [WORD_BITS-1:0] scan_bits;
	logic                 scan_hit;
	logic [BW-1:0]        scan_pos;
	logic [CW-1:0]        word_base;

	always_comb begin
		word_base = CW'(32'(word_q) * WORD_BITS);
		scan_bits = pres_q[word_q];
		for (int b = 0; b < WORD_BITS; b++) begin
			if ((32'(word_base) + 32'(b)) < idx_q || (32'(word_base) + 32'(b)) >= 32'(count))
				scan_bits[b] = 1'b0;
		end
		scan_hit = |scan_bits;
		scan_pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (scan_bits[b]) scan_pos = BW'(b);
		end
	end

	// Decode checks on the incoming item.
	logic [2:0] chk_status;
	logic       chk_pass;
	always_comb begin
		chk_pass = 1'b0;
		chk_status = ST_OK;
		if (req.req_type == REQ_INSERT &&
		    (req.key_len != full_key_len_q || req.payload_len != value_len_q))
			chk_status = ST_CONVERT;
		else if (req.key_len != full_key_len_q)
			chk_status = ST_WRONGLEN;
		else if (((req.key_prefix ^ fence_bytes_q) & byte_mask(pfx_cmp)) != 64'd0)
			chk_status = ST_NORANGE;
		else
			chk_pass = 1'b1;
	end

	logic [31:0] knum_at_idx;
	assign knum_at_idx = array_start_q + idx_q;

	always_ff @(posedge clk) begin
		if (state_q == S_POINT && req_q == REQ_INSERT)
			vals[idx_q[IW-1:0]] <= VALUE_BITS'(pay_q & vmask);
		vrd_q <= vals[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			word_q  <= '0;
			idx_q   <= '0;
			rsp_q   <= '0;
			for (int w = 0; w < WORDS; w++) pres_q[w] <= '0;
		end else begin
			// Raise done in the cycle after the output state.
			done_q <= (state_q == S_OUT);
			case (state_q)
				S_IDLE: begin
					// Take an item only once the previous done cycle is over.
					if (start && !busy) begin
						req_q <= req.req_type;
						pay_q <= req.payload;
						hit_q <= 1'b0;
						rsp_q <= '{status: chk_status, default: '0};
						num_q <= (nlen == 3'd0) ? 32'd0 :
						         (req.key_tail >> (6'd8 * (6'd4 - 6'(nlen))));
						if (chk_pass) begin
							state_q <= S_INDEX;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_INDEX: begin
					// Map the number onto a slot and classify its range.
					idx_q <= num_q - array_start_q;
					if ((num_q - array_start_q) >= 32'(count)) begin
						if (req_q == REQ_SCAN) rsp_q.status <= ST_SCANEND;
						else if ((num_q - array_start_q) < 32'(count_x15))
							rsp_q.status <= ST_SLIGHT;
						else rsp_q.status <= ST_FAR;
						state_q <= S_OUT;
					end else if (req_q == REQ_SCAN) begin
						word_q  <= WW'((num_q - array_start_q) / WORD_BITS);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_POINT;
					end
				end
				S_POINT: begin
					rsp_q.slot_index  <= 10'(idx_q);
					rsp_q.key_numeric <= knum_at_idx;
					if (req_q == REQ_INSERT) begin
						pres_q[idx_word][idx_bit] <= 1'b1;
						rsp_q.status <= ST_OK;
						state_q <= S_OUT;
					end else if (!pres_q[idx_word][idx_bit]) begin
						rsp_q.status <= ST_ABSENT;
						state_q <= S_OUT;
					end else if (req_q == REQ_REMOVE) begin
						pres_q[idx_word][idx_bit] <= 1'b0;
						rsp_q.status <= ST_OK;
						state_q <= S_OUT;
					end else begin
						rsp_q.status <= ST_OK;
						state_q <= S_READ;
					end
				end
				S_SCAN: begin
					// Walk one bitmap word a cycle.
					if (scan_hit) begin
						idx_q   <= 32'(word_base) + 32'(scan_pos);
						rsp_q.status <= ST_OK;
						state_q <= S_READ;
					end else if ((32'(word_base) + 32'(WORD_BITS)) >= 32'(count)) begin
						rsp_q.status <= ST_SCANEND;
						state_q <= S_OUT;
					end else begin
						word_q <= word_q + WW'(1);
					end
				end
				S_READ: begin
					// Store read is registered; present it next cycle.
					rsp_q.slot_index    <= 10'(idx_q);
					rsp_q.key_numeric   <= knum_at_idx;
					rsp_q.value_len_out <= vbytes;
					hit_q   <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (hit_q)
						rsp_q.value_out <= 64'(vrd_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The value word lands in rsp_q at the same edge that raises done.
	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
